@@ hdl/command_frame_crc16_builder_defines.svh @@
// Assertion macros shared by the checker of the command frame CRC builder.
// No dependencies.
`ifndef COMMAND_FRAME_CRC16_BUILDER_DEFINES_SVH
`define COMMAND_FRAME_CRC16_BUILDER_DEFINES_SVH

// same-cycle implication, off while in reset
`define CFCB_ASSERT_NOW(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("cfcb check failed");

// next-cycle implication, off while in reset
`define CFCB_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("cfcb check failed");

// next-cycle implication that also holds through reset
`define CFCB_ASSERT_ALWAYS(lbl, clk, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("cfcb check failed");

`endif

@@ hdl/cfcb_pkg.sv @@
// Package of the command frame CRC builder: queue entry types, constants,
// CRC-16 update and CRC byte escape functions. No dependencies.
`default_nettype none
package cfcb_pkg;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  CR_BYTE   = 8'h0d;
  localparam logic [7:0]  ESC_PAREN = 8'h28;
  localparam logic [7:0]  ESC_CR    = 8'h0d;
  localparam logic [7:0]  ESC_LF    = 8'h0a;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [7:0] crc_hi;
    logic [7:0] crc_lo;
  } qent_t;

  typedef struct packed {
    logic  vld;
    qent_t ent;
  } qpush_t;

  typedef struct packed {
    logic  vld;
    qent_t ent;
  } qhead_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] crc_escape(input logic [7:0] b);
    if (b == ESC_PAREN || b == ESC_CR || b == ESC_LF) begin
      return b + 8'd1;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

@@ hdl/cfcb_front.sv @@
// Front end: accepts command bytes, runs the CRC-16 and pushes classified
// entries into the queue. Depends on cfcb_pkg.
`default_nettype none
module cfcb_front import cfcb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] cmd_byte
  input  wire logic       in_tlast,   // frame_end
  input  wire logic       q_full,
  output qpush_t          push
);

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_new;
  logic        xfer;

  assign in_tready = !q_full;
  assign xfer      = in_tvalid && !q_full;
  assign crc_new   = crc_update(crc_r, in_tdata);

  always_comb begin
    crc_nxt = crc_r;
    if (xfer) begin
      crc_nxt = in_tlast ? 16'h0000 : crc_new;
    end
  end

  always_comb begin
    push.vld        = xfer;
    push.ent.data   = in_tdata;
    push.ent.last   = in_tlast;
    push.ent.crc_hi = crc_escape(crc_new[15:8]);
    push.ent.crc_lo = crc_escape(crc_new[7:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 16'h0000;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/cfcb_queue.sv @@
// Short queue between front and back end of the CRC builder.
// Depends on cfcb_pkg.
`default_nettype none
module cfcb_queue import cfcb_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire qpush_t push,
  output logic        full,
  output qhead_t      head,
  input  wire logic   pop
);

  qent_t        mem [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_pop;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign head.vld = (cnt_r != '0);
  assign head.ent = mem[rptr_r];
  assign do_pop   = pop && head.vld;

  always_comb begin
    wptr_nxt = push.vld ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (QAW+1)'(push.vld) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem[wptr_r] <= push.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/cfcb_back.sv @@
// Back end: pops queue entries and sends the byte, then for a final byte
// the escaped CRC bytes and a carriage return. Depends on cfcb_pkg.
`default_nettype none
module cfcb_back import cfcb_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire qhead_t head,
  output logic        pop,
  output logic        out_tvalid,
  input  wire logic   out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic        out_tlast    // out_last
);

  typedef enum logic [1:0] {
    PH_DATA,
    PH_HI,
    PH_LO,
    PH_CR
  } phase_t;

  phase_t     ph_r, ph_nxt;
  logic [7:0] lo_r, lo_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] dat_r, dat_nxt;
  logic       lst_r, lst_nxt;
  logic       slot_free;

  assign slot_free  = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = dat_r;
  assign out_tlast  = lst_r;

  always_comb begin
    ph_nxt  = ph_r;
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    vld_nxt = vld_r && !out_tready;
    dat_nxt = dat_r;
    lst_nxt = lst_r;
    pop     = 1'b0;
    if (slot_free) begin
      case (ph_r)
        PH_DATA: begin
          if (head.vld) begin
            pop     = 1'b1;
            vld_nxt = 1'b1;
            dat_nxt = head.ent.data;
            lst_nxt = 1'b0;
            hi_nxt  = head.ent.crc_hi;
            lo_nxt  = head.ent.crc_lo;
            ph_nxt  = head.ent.last ? PH_HI : PH_DATA;
          end
        end
        PH_HI: begin
          vld_nxt = 1'b1;
          dat_nxt = hi_r;
          lst_nxt = 1'b0;
          ph_nxt  = PH_LO;
        end
        PH_LO: begin
          vld_nxt = 1'b1;
          dat_nxt = lo_r;
          lst_nxt = 1'b0;
          ph_nxt  = PH_CR;
        end
        PH_CR: begin
          vld_nxt = 1'b1;
          dat_nxt = CR_BYTE;
          lst_nxt = 1'b1;
          ph_nxt  = PH_DATA;
        end
        default: begin
          ph_nxt = PH_DATA;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_DATA;
      vld_r <= 1'b0;
      lst_r <= 1'b0;
    end else begin
      ph_r  <= ph_nxt;
      vld_r <= vld_nxt;
      lst_r <= lst_nxt;
    end
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    dat_r <= dat_nxt;
  end

endmodule
`default_nettype wire

@@ hdl/command_frame_crc16_builder.sv @@
// Top level of the command frame CRC-16 builder.
// Instantiates cfcb_front, cfcb_queue and cfcb_back; depends on cfcb_pkg.
//
// Usage:
//   in_*  : command bytes, in_tdata = cmd_byte, in_tlast marks the final
//           byte of a command.
//   out_* : the same bytes, each passed through unchanged; after a final
//           byte follow the CRC-16 high byte, low byte (0x28, 0x0D and 0x0A
//           bumped by one) and a carriage return with out_tlast high.
//   Path:   a byte is written into the queue, then loaded into the single
//           output register that drives out_*; a stall holds it there.
//   Throughput: one output byte per cycle while out_tready is high; a
//           final byte adds three bytes (CRC high, low, CR) before the next.
//   A four-entry queue separates input and output; in_tready drops only
//           when it is full, so input keeps flowing while output stalls.
//   Reset (rst_n low, synchronous): CRC cleared, queue emptied, output
//           invalid. A stalled output holds its byte until out_tready.
`default_nettype none
module command_frame_crc16_builder import cfcb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] cmd_byte
  input  wire logic       in_tlast,   // frame_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast   // out_last
);

  qpush_t push;
  qhead_t head;
  logic   q_full;
  logic   pop;

  cfcb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push)
  );

  cfcb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  cfcb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

@@ hdl/cfcb_checker.sv @@
// Port-level checker for the command frame CRC builder, bound to the top.
// Depends on cfcb_pkg and command_frame_crc16_builder_defines.svh.
`default_nettype none
`include "command_frame_crc16_builder_defines.svh"
module cfcb_checker import cfcb_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  `CFCB_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n, !out_tvalid)
  `CFCB_ASSERT_NOW(a_last_is_cr, clk, rst_n, out_tvalid && out_tlast, out_tdata == CR_BYTE)
  `CFCB_ASSERT_NOW(a_full_has_out, clk, rst_n, !in_tready, out_tvalid)
  `CFCB_ASSERT_NXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind command_frame_crc16_builder cfcb_checker u_cfcb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
